// ----- src/exp_blur_pkg.sv -----
package exp_blur_pkg;

  // Fixed field widths
  localparam int ADDR_W      = 16;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int SAMPLE_W    = 8;
  localparam int NUM_CH      = 4;
  localparam int WORD_W      = SAMPLE_W * NUM_CH;
  localparam int DIM_W       = 9;
  localparam int NCH_W       = 3;
  localparam int ALPHA_REG_W = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  // Parameter defaults
  localparam int DEF_MAX_WIDTH         = 256;
  localparam int DEF_MAX_HEIGHT        = 256;
  localparam int DEF_ALPHA_BITS        = 16;
  localparam int DEF_ACC_FRACTION_BITS = 7;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2,
    CFG_BLUR_ALPHA    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LINE_RD,
    ST_LINE_LOAD,
    ST_STEP_RD,
    ST_STEP_MUL,
    ST_STEP_WR,
    ST_LINE_END,
    ST_RUN_DONE
  } state_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [ADDR_W-1:0]   pixel_index;
    logic [SAMPLE_W-1:0] in_ch0;
    logic [SAMPLE_W-1:0] in_ch1;
    logic [SAMPLE_W-1:0] in_ch2;
    logic [SAMPLE_W-1:0] in_ch3;
  } in_word_t;

  typedef struct packed {
    cmd_t                done_kind;
    logic [SAMPLE_W-1:0] out_ch0;
    logic [SAMPLE_W-1:0] out_ch1;
    logic [SAMPLE_W-1:0] out_ch2;
    logic [SAMPLE_W-1:0] out_ch3;
  } out_word_t;

endpackage

// ----- src/exponential_blur_engine_top.sv -----
// Channel   Handshake                Payload                     Word
// --------  -----------------------  --------------------------  ------------------------
// in        in_valid / in_stall      in_data (in_word_t)         one command
// out       out_valid / out_stall    out_data (out_word_t)       one result per command
// cfg       cfg_we                   cfg_index, cfg_data         one register write
//
// Sequence: a load writes the store when it is taken; a read goes through the
// registered store read. A run walks the frame with one shared multiply unit;
// each filter step passes through ST_STEP_RD, ST_STEP_MUL and ST_STEP_WR, on
// the single store port that each step reads and then writes back.
// Reset: rst resets the sequencer, output valid and config registers; the
// frame store is not cleared and holds garbage until loaded.
// Stalls: a command is taken only when the sequencer is idle and the output
// register is empty or being drained; a stalled result holds in place.
module exponential_blur_engine_top #(
  parameter int MAX_WIDTH         = exp_blur_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT        = exp_blur_pkg::DEF_MAX_HEIGHT,
  parameter int ALPHA_BITS        = exp_blur_pkg::DEF_ALPHA_BITS,
  parameter int ACC_FRACTION_BITS = exp_blur_pkg::DEF_ACC_FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  exp_blur_pkg::in_word_t                 in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output exp_blur_pkg::out_word_t                out_data,
  input  logic                                   cfg_we,
  input  logic [exp_blur_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [exp_blur_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W = exp_blur_pkg::ADDR_W;
  localparam int DIM_W  = exp_blur_pkg::DIM_W;
  localparam int NCH_W  = exp_blur_pkg::NCH_W;
  localparam int SW     = exp_blur_pkg::SAMPLE_W;
  localparam int WORD_W = exp_blur_pkg::WORD_W;
  // Accumulator holds a sample with ACC_FRACTION_BITS of fraction.
  localparam int ACC_W  = SW + ACC_FRACTION_BITS;
  localparam int DIFF_W = ACC_W + 1;
  localparam int PROD_W = DIFF_W + ALPHA_BITS + 1;

  // Configuration registers
  logic [DIM_W-1:0]                    frame_width;
  logic [DIM_W-1:0]                    frame_height;
  logic [NCH_W-1:0]                    channel_count;
  logic [exp_blur_pkg::ALPHA_REG_W-1:0] blur_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= DIM_W'(1);
      frame_height  <= DIM_W'(1);
      channel_count <= NCH_W'(1);
      blur_alpha    <= '0;
    end else if (cfg_we) begin
      case (exp_blur_pkg::cfg_idx_t'(cfg_index))
        exp_blur_pkg::CFG_FRAME_WIDTH:   frame_width   <= cfg_data[DIM_W-1:0];
        exp_blur_pkg::CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[DIM_W-1:0];
        exp_blur_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[NCH_W-1:0];
        exp_blur_pkg::CFG_BLUR_ALPHA:    blur_alpha    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes: clamp into the supported ranges.
  logic [DIM_W-1:0]      w_eff, h_eff;
  logic [NCH_W-1:0]      nc_eff;
  logic [ALPHA_BITS-1:0] alpha;

  always_comb begin
    if (frame_width == '0)
      w_eff = DIM_W'(1);
    else if (32'(frame_width) > MAX_WIDTH)
      w_eff = DIM_W'(MAX_WIDTH);
    else
      w_eff = frame_width;
    if (frame_height == '0)
      h_eff = DIM_W'(1);
    else if (32'(frame_height) > MAX_HEIGHT)
      h_eff = DIM_W'(MAX_HEIGHT);
    else
      h_eff = frame_height;
    if (channel_count == '0)
      nc_eff = NCH_W'(1);
    else if (channel_count > NCH_W'(exp_blur_pkg::NUM_CH))
      nc_eff = NCH_W'(exp_blur_pkg::NUM_CH);
    else
      nc_eff = channel_count;
    alpha = blur_alpha[ALPHA_BITS-1:0];
  end

  // Frame store: one write port, one registered read port.
  logic [WORD_W-1:0] frame_store [exp_blur_pkg::STORE_DEPTH];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata, rdata;

  always_ff @(posedge clk) begin
    if (mem_we)
      frame_store[mem_waddr] <= mem_wdata;
    rdata <= frame_store[mem_raddr];
  end

  // Sequencer state
  exp_blur_pkg::state_t state, state_next;
  logic                  col_phase;    // 0: row lines, 1: column lines
  logic [DIM_W-1:0]      line;         // current row or column
  logic [1:0]            ch;           // current channel
  logic [1:0]            pass;         // even passes forward, odd backward
  logic [DIM_W-1:0]      steps_left;   // steps left in the current pass
  logic [ADDR_W-1:0]     base;         // address of the line's first sample
  logic [ADDR_W-1:0]     addr;         // address of the current sample

  // Shared filter unit
  logic [ACC_W-1:0]         acc, acc_next;
  logic signed [PROD_W-1:0] prod, prod_sh;
  logic signed [DIFF_W-1:0] diff;
  logic [SW-1:0]            sample;

  logic                      in_acc, out_take, out_load;
  exp_blur_pkg::out_word_t   out_next;

  // Line geometry for the current phase
  logic [DIM_W-1:0]  line_len, line_total;
  logic [ADDR_W-1:0] step_dist, line_inc;
  logic              pass_end, last_ch, last_line;

  always_comb begin
    line_len   = col_phase ? h_eff : w_eff;
    line_total = col_phase ? w_eff : h_eff;
    step_dist  = col_phase ? ADDR_W'(w_eff) : ADDR_W'(1);
    line_inc   = col_phase ? ADDR_W'(1) : ADDR_W'(w_eff);
    pass_end   = (steps_left == DIM_W'(1));
    last_ch    = ({1'b0, ch} == nc_eff - NCH_W'(1));
    last_line  = (line == line_total - DIM_W'(1));
  end

  // Filter arithmetic
  always_comb begin
    sample   = rdata[{ch, 3'b000} +: SW];
    diff     = $signed({1'b0, sample, {ACC_FRACTION_BITS{1'b0}}}) - $signed({1'b0, acc});
    prod_sh  = prod >>> ALPHA_BITS;
    acc_next = acc + prod_sh[ACC_W-1:0];
  end

  assign out_take = out_valid && !out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      exp_blur_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.cmd == exp_blur_pkg::CMD_READ)
            state_next = exp_blur_pkg::ST_READ;
          else if (in_data.cmd == exp_blur_pkg::CMD_RUN)
            state_next = exp_blur_pkg::ST_LINE_RD;
        end
      end
      exp_blur_pkg::ST_READ:      state_next = exp_blur_pkg::ST_IDLE;
      exp_blur_pkg::ST_LINE_RD:   state_next = exp_blur_pkg::ST_LINE_LOAD;
      exp_blur_pkg::ST_LINE_LOAD: begin
        if (line_len == DIM_W'(1))
          state_next = exp_blur_pkg::ST_LINE_END;
        else
          state_next = exp_blur_pkg::ST_STEP_RD;
      end
      exp_blur_pkg::ST_STEP_RD:   state_next = exp_blur_pkg::ST_STEP_MUL;
      exp_blur_pkg::ST_STEP_MUL:  state_next = exp_blur_pkg::ST_STEP_WR;
      exp_blur_pkg::ST_STEP_WR: begin
        if (pass_end && pass == 2'd3)
          state_next = exp_blur_pkg::ST_LINE_END;
        else
          state_next = exp_blur_pkg::ST_STEP_RD;
      end
      exp_blur_pkg::ST_LINE_END: begin
        if (col_phase && last_ch && last_line)
          state_next = exp_blur_pkg::ST_RUN_DONE;
        else
          state_next = exp_blur_pkg::ST_LINE_RD;
      end
      exp_blur_pkg::ST_RUN_DONE:  state_next = exp_blur_pkg::ST_IDLE;
      default:                    state_next = exp_blur_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: store port, input stall, result word
  always_comb begin
    in_stall  = !((state == exp_blur_pkg::ST_IDLE) && (!out_valid || !out_stall));
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = rdata;
    mem_wdata[{ch, 3'b000} +: SW] = acc_next[ACC_W-1 -: SW];
    mem_raddr = addr;
    out_load  = 1'b0;
    out_next  = '0;
    case (state)
      exp_blur_pkg::ST_IDLE: begin
        mem_raddr          = in_data.pixel_index;
        mem_waddr          = in_data.pixel_index;
        mem_wdata          = {in_data.in_ch3, in_data.in_ch2, in_data.in_ch1, in_data.in_ch0};
        out_next.done_kind = in_data.cmd;
        if (in_acc && in_data.cmd == exp_blur_pkg::CMD_LOAD) begin
          mem_we   = 1'b1;
          out_load = 1'b1;
        end
        if (in_acc && in_data.cmd == exp_blur_pkg::CMD_NONE)
          out_load = 1'b1;
      end
      exp_blur_pkg::ST_READ: begin
        out_load           = 1'b1;
        out_next.done_kind = exp_blur_pkg::CMD_READ;
        out_next.out_ch0   = rdata[SW-1:0];
        out_next.out_ch1   = (nc_eff > NCH_W'(1)) ? rdata[2*SW-1:SW] : '0;
        out_next.out_ch2   = (nc_eff > NCH_W'(2)) ? rdata[3*SW-1:2*SW] : '0;
        out_next.out_ch3   = (nc_eff > NCH_W'(3)) ? rdata[4*SW-1:3*SW] : '0;
      end
      exp_blur_pkg::ST_LINE_RD: mem_raddr = base;
      exp_blur_pkg::ST_STEP_WR: mem_we = 1'b1;
      exp_blur_pkg::ST_RUN_DONE: begin
        out_load           = 1'b1;
        out_next.done_kind = exp_blur_pkg::CMD_RUN;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= exp_blur_pkg::ST_IDLE;
      out_valid <= 1'b0;
      col_phase <= 1'b0;
      line      <= '0;
      ch        <= '0;
      pass      <= '0;
    end else begin
      state <= state_next;
      if (out_load)
        out_valid <= 1'b1;
      else if (out_take)
        out_valid <= 1'b0;
      case (state)
        exp_blur_pkg::ST_IDLE: begin
          // start a run on the first row, first channel
          col_phase <= 1'b0;
          line      <= '0;
          ch        <= '0;
        end
        exp_blur_pkg::ST_LINE_LOAD: pass <= '0;
        exp_blur_pkg::ST_STEP_WR: begin
          if (pass_end)
            pass <= pass + 2'd1;
        end
        exp_blur_pkg::ST_LINE_END: begin
          if (last_ch) begin
            ch <= '0;
            if (last_line) begin
              col_phase <= 1'b1;
              line      <= '0;
            end else begin
              line <= line + DIM_W'(1);
            end
          end else begin
            ch <= ch + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (out_load)
      out_data <= out_next;
    case (state)
      exp_blur_pkg::ST_IDLE: base <= '0;
      exp_blur_pkg::ST_LINE_LOAD: begin
        // seed the filter with the first sample, step to the second
        acc        <= {sample, {ACC_FRACTION_BITS{1'b0}}};
        addr       <= base + step_dist;
        steps_left <= line_len - DIM_W'(1);
      end
      exp_blur_pkg::ST_STEP_MUL:
        prod <= diff * $signed({1'b0, alpha});
      exp_blur_pkg::ST_STEP_WR: begin
        acc <= acc_next;
        if (pass_end) begin
          // turn around: the new pass starts one sample the other way
          steps_left <= line_len - DIM_W'(1);
          if (pass[0])
            addr <= addr + step_dist;
          else
            addr <= addr - step_dist;
        end else begin
          steps_left <= steps_left - DIM_W'(1);
          if (pass[0])
            addr <= addr - step_dist;
          else
            addr <= addr + step_dist;
        end
      end
      exp_blur_pkg::ST_LINE_END: begin
        if (last_ch) begin
          if (last_line)
            base <= '0;
          else
            base <= base + line_inc;
        end
      end
      default: ;
    endcase
  end

  // Commands are taken only while the sequencer is idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> state == exp_blur_pkg::ST_IDLE)
    else $error("command accepted while sequencer busy");

  // The store is written only by a load or by a filter write-back.
  a_store_write: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == exp_blur_pkg::ST_STEP_WR) ||
               (in_acc && in_data.cmd == exp_blur_pkg::CMD_LOAD))
    else $error("unexpected store write");

  // A result appears only after a command has been completed.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc) ||
                         $past(state) == exp_blur_pkg::ST_READ ||
                         $past(state) == exp_blur_pkg::ST_RUN_DONE)
    else $error("result without a completed command");

  // A filter step never runs past the end of its pass.
  a_steps_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == exp_blur_pkg::ST_STEP_WR |-> steps_left != '0)
    else $error("filter step counter underflow");

endmodule
